>>> rtl/qswe_pkg.sv
package qswe_pkg;

	localparam int unsigned WINDOW_DEF = 10;

	localparam int CNT_W     = 16;
	localparam int SUM_OUT_W = 20;
	localparam int Q_W       = 48;
	localparam int SCALE_W   = 32;
	localparam int MUL_A_W   = 24;
	localparam int MUL_B_W   = 16;
	localparam int ACC_W     = 64;
	localparam int CFG_IDX_W = 1;
	localparam int M_TDATA_W = 136;

	localparam logic [CFG_IDX_W-1:0] REG_RPM_SCALE   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_WHEEL_SCALE = 1'b1;

	localparam logic [SCALE_W-1:0] RPM_SCALE_RST   = 32'd8936727;
	localparam logic [SCALE_W-1:0] WHEEL_SCALE_RST = 32'd65536;

	// left shift applied to the product before it is added to the accumulator
	typedef enum logic [1:0] {
		SH_0,
		SH_16,
		SH_24
	} mac_shift_t;

	typedef struct packed {
		logic       en;
		logic       load;
		logic       pre_shift;
		mac_shift_t shift;
	} mac_ctl_t;

endpackage

>>> rtl/qswe_ring.sv
module qswe_ring import qswe_pkg::*; #(
	parameter int unsigned WINDOW = WINDOW_DEF,
	parameter int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    clear,
	input  logic                    rd_en,
	input  logic                    wr_en,
	input  logic [PTR_W-1:0]        addr,
	input  logic signed [CNT_W-1:0] wr_data,
	output logic signed [CNT_W-1:0] rd_data
);

	logic signed [CNT_W-1:0] mem [WINDOW];
	logic [WINDOW-1:0]       valid_q;
	logic signed [CNT_W-1:0] rd_data_q;
	logic                    hit_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[addr];
			hit_q     <= valid_q[addr];
		end
	end

	// an entry never written since reset or restart reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (clear) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[addr] <= 1'b1;
		end
	end

	assign rd_data = hit_q ? rd_data_q : '0;

endmodule

>>> rtl/qswe_mac.sv
module qswe_mac import qswe_pkg::*; (
	input  logic               clk,
	input  mac_ctl_t           ctl,
	input  logic [MUL_A_W-1:0] a,
	input  logic [MUL_B_W-1:0] b,
	output logic [ACC_W-1:0]   acc
);

	logic [MUL_A_W+MUL_B_W-1:0] prod;
	logic [ACC_W-1:0]           addend;
	logic [ACC_W-1:0]           base;
	logic [ACC_W-1:0]           acc_q;

	assign prod = a * b;

	always_comb begin
		case (ctl.shift)
			SH_0:    addend = ACC_W'(prod);
			SH_16:   addend = ACC_W'(prod) << 16;
			SH_24:   addend = ACC_W'(prod) << 24;
			default: addend = '0;
		endcase
	end

	// pre_shift drops the fraction of the partial sum before the next term
	assign base = ctl.load ? '0 : (ctl.pre_shift ? (acc_q >> 16) : acc_q);

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			acc_q <= base + addend;
		end
	end

	assign acc = acc_q;

endmodule

>>> rtl/quadrature_speed_window_estimator.sv
// Speed estimator for a quadrature counter sampled once per control tick.
// Slave stream: tdata carries counter_value, tuser carries mode (1 = restart).
// Master stream: one result per input item with count_delta, window_sum,
// shaft_rpm and ground_speed packed in tdata.
// Config channel: cfg_index 0 writes rpm_scale, 1 writes wheel_scale, both
// Q16.16; always ready, write only while no item is in flight.
// An update item passes through the ring read at the transfer, the sum update,
// six passes through the shared 24x16 multiply-accumulate for the two products,
// a saturation step and the output load; the block takes the next item only
// once it is back in idle.
// A restart item clears the window and gives an all-zero result, loaded from
// the final state into the output register; it skips the update steps.
// Reset sets both scales to their defaults, zeroes the sum, the pointer and
// the previous count; the ring's valid bits clear at once, no clearing pass.
// If the receiver stalls, the result holds in the output register; the next
// item is still taken and waits in its last step until the register frees.
module quadrature_speed_window_estimator import qswe_pkg::*; #(
	parameter int unsigned WINDOW = WINDOW_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [CNT_W-1:0]       s_tdata,  // [15:0] counter_value
	input  logic                   s_tuser,  // [0] mode
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// [15:0] count_delta, [35:16] window_sum, [83:36] shaft_rpm,
	// [131:84] ground_speed, [135:132] zero
	output logic [M_TDATA_W-1:0]   m_tdata,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [SCALE_W-1:0]     cfg_data
);

	localparam int PTR_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int SUM_FIT = CNT_W + $clog2(WINDOW);
	localparam int SUM_W   = (SUM_FIT > SUM_OUT_W) ? SUM_FIT : SUM_OUT_W;

	localparam logic [ACC_W-1:0] Q_MAX_U = ACC_W'({1'b0, {(Q_W-1){1'b1}}});
	localparam logic [ACC_W-1:0] Q_MIN_U = ACC_W'({1'b1, {(Q_W-1){1'b0}}});

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD,
		ST_M0,
		ST_M1,
		ST_SAT,
		ST_M2,
		ST_M3,
		ST_M4,
		ST_M5,
		ST_FIN
	} state_t;

	function automatic logic signed [Q_W-1:0] sat_q(input logic neg,
			input logic [ACC_W-1:0] mag);
		logic signed [Q_W-1:0] r;
		if (neg) begin
			r = (mag >= Q_MIN_U) ? Q_MIN_U[Q_W-1:0] : -$signed(mag[Q_W-1:0]);
		end else begin
			r = (mag > Q_MAX_U) ? Q_MAX_U[Q_W-1:0] : $signed(mag[Q_W-1:0]);
		end
		return r;
	endfunction

	state_t                  state_q;
	logic [SCALE_W-1:0]      rpm_scale_q;
	logic [SCALE_W-1:0]      wheel_scale_q;
	logic [CNT_W-1:0]        prev_q;
	logic [PTR_W-1:0]        pos_q;
	logic signed [SUM_W-1:0] sum_q;
	logic signed [CNT_W-1:0] delta_q;
	logic signed [Q_W-1:0]   rpm_q;
	logic [Q_W-1:0]          mag_q;
	logic                    restart_q;

	logic                    in_xfer;
	logic                    ring_clear;
	logic                    ring_rd;
	logic                    ring_wr;
	logic signed [CNT_W-1:0] ring_old;
	logic [SUM_W-1:0]        sum_mag;
	logic signed [Q_W-1:0]   rpm_sat;
	logic signed [Q_W-1:0]   wheel_val;
	logic                    out_free;
	mac_ctl_t                mac_ctl;
	logic [MUL_A_W-1:0]      mac_a;
	logic [MUL_B_W-1:0]      mac_b;
	logic [ACC_W-1:0]        acc;

	assign s_tready   = (state_q == ST_IDLE);
	assign cfg_ready  = 1'b1;
	assign in_xfer    = s_tvalid && s_tready;
	assign ring_clear = in_xfer && s_tuser;
	assign ring_rd    = in_xfer && !s_tuser;
	assign ring_wr    = (state_q == ST_RD);
	assign out_free   = !m_tvalid || m_tready;

	qswe_ring #(
		.WINDOW (WINDOW),
		.PTR_W  (PTR_W)
	) u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.clear   (ring_clear),
		.rd_en   (ring_rd),
		.wr_en   (ring_wr),
		.addr    (pos_q),
		.wr_data (delta_q),
		.rd_data (ring_old)
	);

	assign sum_mag   = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : sum_q;
	assign rpm_sat   = sat_q(sum_q[SUM_W-1], acc);
	assign wheel_val = restart_q ? '0 : sat_q(rpm_q[Q_W-1], acc);

	always_comb begin
		mac_ctl = '{en: 1'b0, load: 1'b0, pre_shift: 1'b0, shift: SH_0};
		mac_a   = '0;
		mac_b   = '0;
		unique case (state_q)
			ST_M0: begin
				mac_ctl = '{en: 1'b1, load: 1'b1, pre_shift: 1'b0, shift: SH_0};
				mac_a   = MUL_A_W'(sum_mag);
				mac_b   = rpm_scale_q[15:0];
			end
			ST_M1: begin
				mac_ctl = '{en: 1'b1, load: 1'b0, pre_shift: 1'b0, shift: SH_16};
				mac_a   = MUL_A_W'(sum_mag);
				mac_b   = rpm_scale_q[31:16];
			end
			// wheel: (mag * lo) >> 16 first, then mag * hi on top
			ST_M2: begin
				mac_ctl = '{en: 1'b1, load: 1'b1, pre_shift: 1'b0, shift: SH_0};
				mac_a   = mag_q[23:0];
				mac_b   = wheel_scale_q[15:0];
			end
			ST_M3: begin
				mac_ctl = '{en: 1'b1, load: 1'b0, pre_shift: 1'b0, shift: SH_24};
				mac_a   = mag_q[47:24];
				mac_b   = wheel_scale_q[15:0];
			end
			ST_M4: begin
				mac_ctl = '{en: 1'b1, load: 1'b0, pre_shift: 1'b1, shift: SH_0};
				mac_a   = mag_q[23:0];
				mac_b   = wheel_scale_q[31:16];
			end
			ST_M5: begin
				mac_ctl = '{en: 1'b1, load: 1'b0, pre_shift: 1'b0, shift: SH_24};
				mac_a   = mag_q[47:24];
				mac_b   = wheel_scale_q[31:16];
			end
			default: begin
			end
		endcase
	end

	qswe_mac u_mac (
		.clk (clk),
		.ctl (mac_ctl),
		.a   (mac_a),
		.b   (mac_b),
		.acc (acc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rpm_scale_q   <= RPM_SCALE_RST;
			wheel_scale_q <= WHEEL_SCALE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_RPM_SCALE:   rpm_scale_q   <= cfg_data;
				REG_WHEEL_SCALE: wheel_scale_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			prev_q    <= '0;
			pos_q     <= '0;
			sum_q     <= '0;
			delta_q   <= '0;
			rpm_q     <= '0;
			mag_q     <= '0;
			restart_q <= 1'b0;
			m_tvalid  <= 1'b0;
			m_tdata   <= '0;
		end else begin
			if (state_q == ST_FIN && out_free) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						prev_q    <= s_tdata;
						restart_q <= s_tuser;
						if (s_tuser) begin
							sum_q   <= '0;
							pos_q   <= '0;
							state_q <= ST_FIN;
						end else begin
							delta_q <= $signed(s_tdata - prev_q);
							state_q <= ST_RD;
						end
					end
				end
				ST_RD: begin
					sum_q   <= sum_q - SUM_W'(ring_old) + SUM_W'(delta_q);
					pos_q   <= (pos_q == PTR_W'(WINDOW - 1)) ? '0 : pos_q + 1'b1;
					state_q <= ST_M0;
				end
				ST_M0:  state_q <= ST_M1;
				ST_M1:  state_q <= ST_SAT;
				ST_SAT: begin
					rpm_q   <= rpm_sat;
					mag_q   <= rpm_sat[Q_W-1] ? Q_W'(-rpm_sat) : rpm_sat;
					state_q <= ST_M2;
				end
				ST_M2:  state_q <= ST_M3;
				ST_M3:  state_q <= ST_M4;
				ST_M4:  state_q <= ST_M5;
				ST_M5:  state_q <= ST_FIN;
				ST_FIN: begin
					if (out_free) begin
						m_tdata  <= {
							(M_TDATA_W - CNT_W - SUM_OUT_W - 2 * Q_W)'(0),
							wheel_val,
							restart_q ? {Q_W{1'b0}} : rpm_q,
							restart_q ? {SUM_OUT_W{1'b0}} : sum_q[SUM_OUT_W-1:0],
							restart_q ? {CNT_W{1'b0}} : delta_q
						};
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= PTR_W'(WINDOW - 1))
		else $error("ring pointer past window");

	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser |=> sum_q == '0 && pos_q == '0)
		else $error("restart did not clear window");

	a_wheel_sign: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FIN && !restart_q && !rpm_q[Q_W-1] |-> !wheel_val[Q_W-1])
		else $error("wheel speed sign differs from shaft speed");

endmodule

>>> tb/qswe_result_checker.sv
module qswe_result_checker import qswe_pkg::*; #(
	parameter int unsigned WINDOW = WINDOW_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [CNT_W-1:0]     s_tdata,
	input  logic                 s_tuser,
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [M_TDATA_W-1:0] m_tdata,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SCALE_W-1:0]   cfg_data,
	output int                   fails,
	output int                   outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic signed [CNT_W-1:0]     delta;
		logic signed [SUM_OUT_W-1:0] sum;
		logic signed [Q_W-1:0]       shaft;
		logic signed [Q_W-1:0]       wheel;
	} speed_result_t;

	localparam longint Q48_MAX = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint Q48_MIN = -64'sh0000_8000_0000_0000;

	logic [SCALE_W-1:0] rpm_gain = RPM_SCALE_RST;
	logic [SCALE_W-1:0] wheel_gain = WHEEL_SCALE_RST;
	logic [CNT_W-1:0]   last_count = '0;
	int                 delta_hist [WINDOW];
	int                 sum_exact = 0;
	int unsigned        slot = 0;
	int                 mismatch_count = 0;
	int                 queued = 0;
	speed_result_t      expected_speeds [$];

	assign fails = mismatch_count;
	assign outstanding = queued;

	function automatic longint clamp_q48(longint v);
		if (v > Q48_MAX)
			return Q48_MAX;
		if (v < Q48_MIN)
			return Q48_MIN;
		return v;
	endfunction

	// (rpm * gain) >> 16, truncated toward zero, saturated
	function automatic longint wheel_from_rpm(longint rpm, logic [SCALE_W-1:0] gain);
		logic            neg;
		longint unsigned mag;
		longint unsigned hi;
		longint unsigned lo;
		longint unsigned q;
		neg = rpm < 0;
		mag = neg ? -rpm : rpm;
		hi = 64'(gain[31:16]);
		lo = 64'(gain[15:0]);
		q = mag * hi + ((mag * lo) >> 16);
		if (neg)
			return (q >= 64'h8000_0000_0000) ? Q48_MIN : -longint'(q);
		return (q > 64'h7FFF_FFFF_FFFF) ? Q48_MAX : longint'(q);
	endfunction

	function automatic speed_result_t predict_speed(logic restart, logic [CNT_W-1:0] cnt);
		speed_result_t           r;
		logic signed [CNT_W-1:0] d;
		longint                  rpm;
		longint                  whl;
		if (restart) begin
			foreach (delta_hist[i])
				delta_hist[i] = 0;
			sum_exact = 0;
			slot = 0;
			last_count = cnt;
			return '0;
		end
		d = cnt - last_count;
		last_count = cnt;
		sum_exact = sum_exact - delta_hist[slot] + int'(d);
		delta_hist[slot] = int'(d);
		slot = (slot + 1) % WINDOW;
		rpm = clamp_q48(longint'(sum_exact) * $signed({32'd0, rpm_gain}));
		whl = wheel_from_rpm(rpm, wheel_gain);
		r.delta = d;
		r.sum = sum_exact[SUM_OUT_W-1:0];
		r.shaft = rpm[Q_W-1:0];
		r.wheel = whl[Q_W-1:0];
		return r;
	endfunction

	task automatic field_check(string what, longint want, longint got);
		if (want != got) begin
			mismatch_count++;
			$display("%0t %s: expected %0d (%h) actual %0d (%h)",
				$time, what, want, want, got, got);
		end
	endtask

	task automatic check_result(logic [M_TDATA_W-1:0] got);
		speed_result_t want;
		if (expected_speeds.size() == 0) begin
			mismatch_count++;
			$display("%0t unexpected result: expected none actual %h", $time, got);
			return;
		end
		want = expected_speeds.pop_front();
		field_check("count_delta", want.delta, $signed(got[15:0]));
		field_check("window_sum", want.sum, $signed(got[35:16]));
		field_check("shaft_rpm", want.shaft, $signed(got[83:36]));
		field_check("ground_speed", want.wheel, $signed(got[131:84]));
		field_check("pad", 0, 64'(got[135:132]));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rpm_gain = RPM_SCALE_RST;
			wheel_gain = WHEEL_SCALE_RST;
			last_count = '0;
			foreach (delta_hist[i])
				delta_hist[i] = 0;
			sum_exact = 0;
			slot = 0;
			expected_speeds.delete();
		end else begin
			// results leave before this edge's input is predicted
			if (m_tvalid && m_tready)
				check_result(m_tdata);
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_RPM_SCALE:   rpm_gain = cfg_data;
					REG_WHEEL_SCALE: wheel_gain = cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				expected_speeds.push_back(predict_speed(s_tuser, s_tdata));
		end
		queued = expected_speeds.size();
	end

endmodule

>>> tb/tb_quadrature_speed_window_estimator.sv
module tb_quadrature_speed_window_estimator;
	import qswe_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_RANDOM,
		RX_BURSTY
	} rx_style_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [CNT_W-1:0]     s_tdata = '0;
	logic                 s_tuser = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = REG_RPM_SCALE;
	logic [SCALE_W-1:0]   cfg_data = '0;

	int        fails;
	int        outstanding;
	rx_style_t rx_style = RX_OPEN;
	logic      rx_hold_go = 1'b0;
	logic      src_gaps = 1'b0;
	int        burst_left = 0;
	logic [CNT_W-1:0] shaft_pos = '0;

	quadrature_speed_window_estimator DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	qswe_result_checker #(.WINDOW(WINDOW_DEF)) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fails      (fails),
		.outstanding(outstanding)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("tb_quadrature_speed_window_estimator NOT OK");
		$finish;
	end

	// receiver: open, random or bursty, plus one long hold-off on request
	initial begin
		int   hold_left;
		int   run_left;
		logic run_ready;
		logic hold_done;
		hold_left = 0;
		run_left = 0;
		run_ready = 1'b0;
		hold_done = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_go && !hold_done) begin
				hold_left = 400;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready = 1'b0;
			end else begin
				case (rx_style)
					RX_OPEN:   m_tready = 1'b1;
					RX_RANDOM: m_tready = ($urandom_range(0, 99) < 65);
					default: begin
						if (run_left == 0) begin
							run_ready = !run_ready;
							run_left = run_ready ? $urandom_range(1, 8) : $urandom_range(1, 15);
						end
						run_left--;
						m_tready = run_ready;
					end
				endcase
			end
		end
	end

	// called at a falling edge, returns at the falling edge after the transfer
	task automatic send_sample(logic restart, logic [CNT_W-1:0] cnt);
		if (burst_left == 0) begin
			if (src_gaps && $urandom_range(0, 3) != 0) begin
				s_tvalid = 1'b0;
				repeat ($urandom_range(1, 25)) @(negedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		s_tvalid = 1'b1;
		s_tuser = restart;
		s_tdata = cnt;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
		burst_left--;
	endtask

	task automatic wait_idle();
		s_tvalid = 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (12) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SCALE_W-1:0] val);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// mostly runs of plausible motion, some after a restart; some raw noise
	task automatic run_random(int n);
		int sent;
		int seg_len;
		int kind;
		int vel;
		sent = 0;
		while (sent < n) begin
			seg_len = $urandom_range(5, 40);
			kind = $urandom_range(0, 9);
			if (kind == 0) begin
				repeat (seg_len) begin
					send_sample(1'($urandom_range(0, 1)), CNT_W'($urandom_range(0, 16'hFFFF)));
					sent++;
				end
			end else begin
				if (kind <= 2)
					vel = $urandom_range(0, 1) ? 32767 : -32768;
				else if (kind <= 4)
					vel = int'($urandom_range(0, 16000)) - 8000;
				else
					vel = int'($urandom_range(0, 400)) - 200;
				if ($urandom_range(0, 9) < 3) begin
					shaft_pos = CNT_W'($urandom_range(0, 16'hFFFF));
					send_sample(1'b1, shaft_pos);
					sent++;
				end
				repeat (seg_len) begin
					if (kind <= 2)
						shaft_pos = CNT_W'(int'(shaft_pos) + vel);
					else
						shaft_pos = CNT_W'(int'(shaft_pos) + vel
							+ int'($urandom_range(0, 6)) - 3);
					send_sample(1'b0, shaft_pos);
					sent++;
				end
			end
		end
	endtask

	initial begin
		logic [SCALE_W-1:0] rpm_plan [6];
		logic [SCALE_W-1:0] wheel_plan [6];
		rx_style_t          rx_plan [6];
		logic               gap_plan [6];
		rpm_plan = '{32'hFFFF_FFFF, 32'h0, $urandom(), 32'h1, 32'd8936727, $urandom()};
		wheel_plan = '{32'hFFFF_FFFF, 32'h0, $urandom(), 32'h1,
			$urandom_range(0, 32'h10_0000), 32'hFFFF_FFFF};
		rx_plan = '{RX_RANDOM, RX_OPEN, RX_BURSTY, RX_OPEN, RX_BURSTY, RX_RANDOM};
		gap_plan = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};

		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed, reset scales: restart, zero delta, full positive window,
		// then full negative window
		rx_style = RX_RANDOM;
		src_gaps = 1'b1;
		shaft_pos = 16'h1234;
		send_sample(1'b1, shaft_pos);
		send_sample(1'b0, shaft_pos);
		repeat (12) begin
			shaft_pos = shaft_pos + 16'h7FFF;
			send_sample(1'b0, shaft_pos);
		end
		repeat (11) begin
			shaft_pos = shaft_pos - 16'h8000;
			send_sample(1'b0, shaft_pos);
		end

		for (int p = 0; p < 6; p++) begin
			wait_idle();
			write_reg(REG_RPM_SCALE, rpm_plan[p]);
			write_reg(REG_WHEEL_SCALE, wheel_plan[p]);
			rx_style = rx_plan[p];
			src_gaps = gap_plan[p];
			// output stalls long enough to back the input up
			if (p == 1)
				rx_hold_go = 1'b1;
			run_random(115);
		end

		s_tvalid = 1'b0;
		rx_style = RX_OPEN;
		while (outstanding != 0)
			@(negedge clk);
		repeat (30) @(negedge clk);
		if (fails == 0)
			$display("tb_quadrature_speed_window_estimator OK");
		else
			$display("tb_quadrature_speed_window_estimator NOT OK");
		$finish;
	end

endmodule
